// ===== src/jfs_pkg.sv =====
// shared types and constants of the job queue
package jfs_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int S_DATA_W        = 80;
	localparam int S_USER_W        = 3;
	localparam int M_DATA_W        = 96;
	localparam int M_USER_W        = 2;

	typedef enum logic [2:0] {
		REQ_ADD    = 3'd0,
		REQ_PRINT  = 3'd1,
		REQ_FIND   = 3'd2,
		REQ_REMOVE = 3'd3,
		REQ_LIST   = 3'd4,
		REQ_CLEAR  = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_SHIFT,
		CELL_ROTATE,
		CELL_CLEAR
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_FINISH
	} fsm_state_t;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] user;
		logic [31:0] doc;
		logic [15:0] pages;
	} job_t;

	typedef struct packed {
		cell_op_t op;
		logic     keep;
	} chain_cmd_t;

endpackage

// ===== src/jfs_cell.sv =====
// one queue slot of the job chain
module jfs_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  jfs_pkg::chain_cmd_t cmd,
	input  logic               prev_valid,
	input  logic               next_valid,
	input  jfs_pkg::job_t      next_job,
	input  jfs_pkg::job_t      head_job,
	input  jfs_pkg::job_t      new_job,
	output logic               valid,
	output jfs_pkg::job_t      job
);
	import jfs_pkg::*;

	logic valid_q;
	job_t job_q;
	logic is_tail;

	assign is_tail = valid_q && !next_valid;
	assign valid   = valid_q;
	assign job     = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				CELL_LOAD: begin
					if (!valid_q && prev_valid) valid_q <= 1'b1;
				end
				CELL_SHIFT: valid_q <= next_valid;
				CELL_ROTATE: begin
					if (is_tail) valid_q <= cmd.keep;
					else valid_q <= next_valid;
				end
				CELL_CLEAR: valid_q <= 1'b0;
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_LOAD: begin
				if (!valid_q && prev_valid) job_q <= new_job;
			end
			CELL_SHIFT: job_q <= next_job;
			CELL_ROTATE: begin
				if (is_tail) job_q <= head_job;
				else job_q <= next_job;
			end
			default: job_q <= job_q;
		endcase
	end

endmodule

// ===== src/jfs_ctrl.sv =====
// request sequencer, counters and result register of the job queue
module jfs_ctrl #(
	parameter int QUEUE_DEPTH = jfs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [jfs_pkg::S_DATA_W-1:0]  s_axis_tdata,
	input  logic [jfs_pkg::S_USER_W-1:0]  s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [jfs_pkg::M_DATA_W-1:0]  m_axis_tdata,
	output logic [jfs_pkg::M_USER_W-1:0]  m_axis_tuser,
	output logic                          m_axis_tlast,
	input  jfs_pkg::job_t                 head_job,
	output jfs_pkg::chain_cmd_t           cmd,
	output jfs_pkg::job_t                 new_job
);
	import jfs_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	fsm_state_t    state_q, state_d;
	logic [2:0]    req_q;
	logic [15:0]   user_q, pages_q, sid_q;
	logic [31:0]   doc_q;
	logic [15:0]   id_q, id_d, next_id;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] walk_len_q, walk_len_d;
	logic [CW-1:0] step_q, step_d;
	logic [CW-1:0] removed_q, removed_d;
	logic          found_q, found_d;
	job_t          found_job_q, found_job_d;

	logic          out_valid_q;
	status_t       out_status_q;
	job_t          out_job_q;
	logic [4:0]    out_removed_q, out_pending_q;
	logic          out_last_q;

	logic          out_free;
	logic          list_beat;
	logic          emit;
	status_t       emit_status;
	job_t          emit_job;
	logic [CW-1:0] emit_removed, emit_pending;
	logic          emit_last;
	logic [CW+4:0] removed_ext, pending_ext;

	assign s_axis_tready = (state_q == S_IDLE);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign next_id       = (id_q == 16'hFFFF) ? 16'd1 : id_q + 16'd1;
	assign list_beat     = (req_q == REQ_LIST) && (32'(step_q) < MAX_RESULTS);
	assign removed_ext   = (CW + 5)'(emit_removed);
	assign pending_ext   = (CW + 5)'(emit_pending);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		id_d         = id_q;
		count_d      = count_q;
		walk_len_d   = walk_len_q;
		step_d       = step_q;
		removed_d    = removed_q;
		found_d      = found_q;
		found_job_d  = found_job_q;
		cmd.op       = CELL_HOLD;
		cmd.keep     = 1'b1;
		new_job      = '{id: next_id, user: user_q, doc: doc_q, pages: pages_q};
		emit         = 1'b0;
		emit_status  = ST_OK;
		emit_job     = '0;
		emit_removed = '0;
		emit_pending = count_q;
		emit_last    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid && (s_axis_tuser <= REQ_CLEAR)) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					if (req_q == REQ_ADD) begin
						if (count_q == CW'(QUEUE_DEPTH)) begin
							emit_status = ST_FULL;
						end else begin
							id_d         = next_id;
							cmd.op       = CELL_LOAD;
							count_d      = count_q + CW'(1);
							emit_job     = new_job;
							emit_pending = count_q + CW'(1);
						end
					end else if (count_q == '0) begin
						emit_status = ST_EMPTY;
					end else begin
						case (req_q)
							REQ_PRINT: begin
								cmd.op       = CELL_SHIFT;
								count_d      = count_q - CW'(1);
								emit_job     = head_job;
								emit_pending = count_q - CW'(1);
							end
							REQ_CLEAR: begin
								cmd.op       = CELL_CLEAR;
								count_d      = '0;
								emit_removed = count_q;
								emit_pending = '0;
							end
							default: begin
								emit       = 1'b0;
								walk_len_d = count_q;
								step_d     = '0;
								removed_d  = '0;
								found_d    = 1'b0;
								state_d    = S_WALK;
							end
						endcase
					end
				end
			end
			S_WALK: begin
				if (!list_beat || out_free) begin
					cmd.op   = CELL_ROTATE;
					cmd.keep = !((req_q == REQ_REMOVE) && (head_job.user == user_q));
					if (!cmd.keep) begin
						count_d   = count_q - CW'(1);
						removed_d = removed_q + CW'(1);
					end
					if ((req_q == REQ_FIND) && !found_q && (head_job.id == sid_q)) begin
						found_d     = 1'b1;
						found_job_d = head_job;
					end
					if (list_beat) begin
						emit      = 1'b1;
						emit_job  = head_job;
						emit_last = (32'(step_q) + 1 == 32'(walk_len_q)) ||
							(32'(step_q) + 1 == MAX_RESULTS);
					end
					step_d = step_q + CW'(1);
					if (step_q == walk_len_q - CW'(1)) begin
						state_d = (req_q == REQ_LIST) ? S_IDLE : S_FINISH;
					end
				end
			end
			S_FINISH: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					if (req_q == REQ_FIND) begin
						if (found_q) emit_job = found_job_q;
						else emit_status = ST_NOTFOUND;
					end else begin
						emit_removed = removed_q;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q        <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			id_q    <= id_d;
			count_q <= count_d;
			if (emit) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_q   <= s_axis_tuser;
			user_q  <= s_axis_tdata[15:0];
			doc_q   <= s_axis_tdata[47:16];
			pages_q <= s_axis_tdata[63:48];
			sid_q   <= s_axis_tdata[79:64];
		end
		walk_len_q  <= walk_len_d;
		step_q      <= step_d;
		removed_q   <= removed_d;
		found_q     <= found_d;
		found_job_q <= found_job_d;
		if (emit) begin
			out_status_q  <= emit_status;
			out_job_q     <= emit_job;
			out_removed_q <= removed_ext[4:0];
			out_pending_q <= pending_ext[4:0];
			out_last_q    <= emit_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {6'd0, out_pending_q, out_removed_q, out_job_q.pages,
		out_job_q.doc, out_job_q.user, out_job_q.id};

endmodule

// ===== src/job_fifo_with_search_and_purge.sv =====
// Print-job queue built as a chain of slots: slot 0 is the head and every slot takes its
// neighbor's job when the queue pops or walks. Add, print-next, clear and requests on an
// empty queue give their result from the execute state through the output register. Find and
// remove-by-user walk the chain once, one slot per cycle, rotating the head job to the tail (or
// dropping it on a purge) so order is kept, then report from a finish state. List gives one
// result beat per cycle of that walk while the output is taken, reporting at most the first
// 16 jobs. A new request is taken once the previous one has finished its walk and emitted
// its final result; that result may still wait in the output register.
module job_fifo_with_search_and_purge #(
	parameter int QUEUE_DEPTH = jfs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// user_tag, doc_handle, page_count, search_id
	input  logic [jfs_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// req_type
	input  logic [jfs_pkg::S_USER_W-1:0]  s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// job_id, job_user, job_doc, job_pages, removed_count, pending_count
	output logic [jfs_pkg::M_DATA_W-1:0]  m_axis_tdata,
	// status
	output logic [jfs_pkg::M_USER_W-1:0]  m_axis_tuser,
	output logic                          m_axis_tlast
);
	import jfs_pkg::*;

	chain_cmd_t cmd;
	job_t       new_job;
	logic       valid_w [QUEUE_DEPTH];
	job_t       job_w   [QUEUE_DEPTH];

	jfs_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.head_job      (job_w[0]),
		.cmd           (cmd),
		.new_job       (new_job)
	);

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic prev_valid;
		logic next_valid;
		job_t next_job;

		if (i == 0) begin : g_first
			assign prev_valid = 1'b1;
		end else begin : g_mid
			assign prev_valid = valid_w[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_valid = 1'b0;
			assign next_job   = '0;
		end else begin : g_inner
			assign next_valid = valid_w[i+1];
			assign next_job   = job_w[i+1];
		end

		jfs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_valid (prev_valid),
			.next_valid (next_valid),
			.next_job   (next_job),
			.head_job   (job_w[0]),
			.new_job    (new_job),
			.valid      (valid_w[i]),
			.job        (job_w[i])
		);
	end

endmodule

// ===== src/jfs_check.sv =====
// port-level checks of the job queue, bound to the top level
module jfs_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [jfs_pkg::M_DATA_W-1:0]  m_axis_tdata,
	input logic [jfs_pkg::M_USER_W-1:0]  m_axis_tuser,
	input logic                          m_axis_tlast
);
	import jfs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
			$stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result beat changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |->
			(m_axis_tdata[89:80] == 10'd0) && (m_axis_tdata[15:0] == 16'd0) && m_axis_tlast)
		else $error("empty status with jobs or removals");

	a_list_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> (m_axis_tuser == ST_OK) &&
			(m_axis_tdata[15:0] != 16'd0))
		else $error("non-final beat without a listed job");

	a_no_job: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ((m_axis_tuser == ST_FULL) || (m_axis_tuser == ST_NOTFOUND)) |->
			(m_axis_tdata[79:0] == 80'd0) && m_axis_tlast)
		else $error("refused or missed request reports a job");

endmodule

bind job_fifo_with_search_and_purge jfs_check u_jfs_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
